### rtl/elgamal_encrypt_decrypt_32bit_defines.svh
// Assertion helpers for the ElGamal core; clk and rst_n must be in scope.
`ifndef ELGAMAL_ENCRYPT_DECRYPT_32BIT_DEFINES_SVH
`define ELGAMAL_ENCRYPT_DECRYPT_32BIT_DEFINES_SVH

// Same-cycle implication
`define EED_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define EED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/eed_pkg.sv
package eed_pkg;

    localparam int WORD_BITS_DEF = 32;

    // configuration register indexes
    localparam logic [1:0] REG_PRIME     = 2'd0;
    localparam logic [1:0] REG_GENERATOR = 2'd1;
    localparam logic [1:0] REG_PUBLIC    = 2'd2;
    localparam logic [1:0] REG_PRIVATE   = 2'd3;

    localparam logic [31:0] PRIME_RST     = 32'd3;
    localparam logic [31:0] GENERATOR_RST = 32'd2;
    localparam logic [31:0] PUBLIC_RST    = 32'd1;
    localparam logic [31:0] PRIVATE_RST   = 32'd1;

    // status of the shared modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

endpackage

### rtl/eed_modmul.sv
// Interleaved shift-add modular multiplier: result = op_a * op_b mod modulus.
// op_b must already be below the modulus; op_a may be any word.
// One bit of op_a per cycle, MSB first; done pulses once the last bit has been added in.
module eed_modmul #(
    parameter int WORD_BITS = eed_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] op_a,
    input  logic [WORD_BITS-1:0] op_b,
    input  logic [WORD_BITS-1:0] modulus,
    output eed_pkg::mm_stat_t    stat,
    output logic [WORD_BITS-1:0] result
);

    localparam int CW = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] a_reg;
    logic [WORD_BITS-1:0] b_reg;
    logic [WORD_BITS-1:0] acc_reg;
    logic [WORD_BITS-1:0] acc_next;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [WORD_BITS:0] mod_w;
    logic [WORD_BITS:0] dbl;
    logic [WORD_BITS:0] red1;
    logic [WORD_BITS:0] sum;
    logic [WORD_BITS:0] red2;

    always_comb
    begin
        mod_w    = {1'b0, modulus};
        dbl      = {acc_reg, 1'b0};
        red1     = (dbl >= mod_w) ? (dbl - mod_w) : dbl;
        sum      = red1 + (a_reg[WORD_BITS-1] ? {1'b0, b_reg} : '0);
        red2     = (sum >= mod_w) ? (sum - mod_w) : sum;
        acc_next = red2[WORD_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(WORD_BITS);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            a_reg   <= a_reg << 1;
            acc_reg <= acc_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = acc_reg;

endmodule

### rtl/elgamal_encrypt_decrypt_32bit.sv
// ElGamal encrypt/decrypt core over a prime modulus of up to WORD_BITS bits.
// s_tuser[0] selects the operation (0 encrypt, 1 decrypt). Encrypt returns
// c1 = g^r mod p and c2 = (m mod p)(y^r mod p) mod p; decrypt returns
// c1^(p-1-d)(c2 mod p) mod p with a zero second word. A modulus below two skips
// every product and gives zeros. All arithmetic runs through one shift-add
// modular multiplier; each product holds the sequencer through its start, WORD_BITS
// shift steps and done. The sequencer walks the exponent bits right to left,
// returning to the check state after each bit, and stops once the remaining exponent
// is zero. An encrypt runs 3 + 2*n + 2*k + 1 products and a decrypt runs
// 2 + n + k + 1, with n the exponent's bit length and k its set bits. The input
// is taken only while the core is idle; a finished result sits in an output
// register so the next transaction can be taken while it waits.
`include "elgamal_encrypt_decrypt_32bit_defines.svh"

module elgamal_encrypt_decrypt_32bit #(
    parameter int WORD_BITS = eed_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [WORD_BITS-1:0] cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // message_block, random_exponent, cipher_first, cipher_second
    input  logic [((4*WORD_BITS+7)/8)*8-1:0] s_tdata,
    // req_type
    input  logic [0:0]           s_tuser,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // result_first, result_second
    output logic [((2*WORD_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int W      = WORD_BITS;
    localparam int OUT_W  = ((2*W+7)/8)*8;

    typedef enum logic [3:0] {
        S_IDLE, S_RED_B1, S_RED_B2, S_RED_M, S_CHECK,
        S_MUL_A1, S_MUL_A2, S_SQ_B1, S_SQ_B2, S_FINAL, S_DONE
    } state_t;

    state_t state_reg;

    logic [W-1:0] prime_reg;
    logic [W-1:0] gen_reg;
    logic [W-1:0] pub_reg;
    logic [W-1:0] priv_reg;

    logic [W-1:0] b1_reg;
    logic [W-1:0] b2_reg;
    logic [W-1:0] a1_reg;
    logic [W-1:0] a2_reg;
    logic [W-1:0] e_reg;
    logic [W-1:0] m_reg;
    logic         enc_reg;
    logic         issued_reg;

    logic [W-1:0] res_first_reg;
    logic [W-1:0] res_second_reg;
    logic         out_valid_reg;

    logic         mul_state;
    logic         mm_start;
    logic [W-1:0] mm_a;
    logic [W-1:0] mm_b;
    logic [W-1:0] mm_res;
    eed_pkg::mm_stat_t mm_stat;

    logic         in_acc;
    logic         in_enc;
    logic [W-1:0] in_msg;
    logic [W-1:0] in_rnd;
    logic [W-1:0] in_c1;
    logic [W-1:0] in_c2;

    assign in_msg = s_tdata[W-1:0];
    assign in_rnd = s_tdata[2*W-1:W];
    assign in_c1  = s_tdata[3*W-1:2*W];
    assign in_c2  = s_tdata[4*W-1:3*W];
    assign in_enc = !s_tuser[0];

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg <= W'(eed_pkg::PRIME_RST);
            gen_reg   <= W'(eed_pkg::GENERATOR_RST);
            pub_reg   <= W'(eed_pkg::PUBLIC_RST);
            priv_reg  <= W'(eed_pkg::PRIVATE_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                eed_pkg::REG_PRIME:     prime_reg <= cfg_data;
                eed_pkg::REG_GENERATOR: gen_reg   <= cfg_data;
                eed_pkg::REG_PUBLIC:    pub_reg   <= cfg_data;
                eed_pkg::REG_PRIVATE:   priv_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // operand selection for the shared multiplier; reductions use b = 1
    always_comb
    begin
        mul_state = 1'b1;
        mm_a      = b1_reg;
        mm_b      = W'(1);
        case (state_reg)
            S_RED_B1: begin mm_a = b1_reg; mm_b = W'(1);  end
            S_RED_B2: begin mm_a = b2_reg; mm_b = W'(1);  end
            S_RED_M:  begin mm_a = m_reg;  mm_b = W'(1);  end
            S_MUL_A1: begin mm_a = a1_reg; mm_b = b1_reg; end
            S_MUL_A2: begin mm_a = a2_reg; mm_b = b2_reg; end
            S_SQ_B1:  begin mm_a = b1_reg; mm_b = b1_reg; end
            S_SQ_B2:  begin mm_a = b2_reg; mm_b = b2_reg; end
            S_FINAL:  begin mm_a = enc_reg ? a2_reg : a1_reg; mm_b = m_reg; end
            default:  mul_state = 1'b0;
        endcase
    end

    assign mm_start = mul_state && !issued_reg;

    eed_modmul #(
        .WORD_BITS (W)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .modulus (prime_reg),
        .stat    (mm_stat),
        .result  (mm_res)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
            else if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;
            if (mm_start)
                issued_reg <= 1'b1;
            else if (mm_stat.done)
                issued_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                        state_reg <= (prime_reg > W'(1)) ? S_RED_B1 : S_DONE;
                end
                S_RED_B1:
                begin
                    if (mm_stat.done)
                        state_reg <= enc_reg ? S_RED_B2 : S_RED_M;
                end
                S_RED_B2:
                begin
                    if (mm_stat.done)
                        state_reg <= S_RED_M;
                end
                S_RED_M:
                begin
                    if (mm_stat.done)
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (e_reg == '0)
                        state_reg <= S_FINAL;
                    else if (e_reg[0])
                        state_reg <= S_MUL_A1;
                    else
                        state_reg <= S_SQ_B1;
                end
                S_MUL_A1:
                begin
                    if (mm_stat.done)
                        state_reg <= enc_reg ? S_MUL_A2 : S_SQ_B1;
                end
                S_MUL_A2:
                begin
                    if (mm_stat.done)
                        state_reg <= S_SQ_B1;
                end
                S_SQ_B1:
                begin
                    if (mm_stat.done)
                        state_reg <= enc_reg ? S_SQ_B2 : S_CHECK;
                end
                S_SQ_B2:
                begin
                    if (mm_stat.done)
                        state_reg <= S_CHECK;
                end
                S_FINAL:
                begin
                    if (mm_stat.done)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    enc_reg <= in_enc;
                    b1_reg  <= in_enc ? gen_reg : in_c1;
                    b2_reg  <= pub_reg;
                    e_reg   <= in_enc ? in_rnd : (prime_reg - W'(1) - priv_reg);
                    m_reg   <= in_enc ? in_msg : in_c2;
                    // a modulus below two short-cuts straight to a zero result
                    a1_reg  <= (prime_reg > W'(1)) ? W'(1) : '0;
                    a2_reg  <= (prime_reg > W'(1)) ? W'(1) : '0;
                end
            end
            S_RED_B1: if (mm_stat.done) b1_reg <= mm_res;
            S_RED_B2: if (mm_stat.done) b2_reg <= mm_res;
            S_RED_M:  if (mm_stat.done) m_reg  <= mm_res;
            S_MUL_A1: if (mm_stat.done) a1_reg <= mm_res;
            S_MUL_A2: if (mm_stat.done) a2_reg <= mm_res;
            S_SQ_B1:
            begin
                if (mm_stat.done)
                begin
                    b1_reg <= mm_res;
                    if (!enc_reg)
                        e_reg <= e_reg >> 1;
                end
            end
            S_SQ_B2:
            begin
                if (mm_stat.done)
                begin
                    b2_reg <= mm_res;
                    e_reg  <= e_reg >> 1;
                end
            end
            S_FINAL:
            begin
                if (mm_stat.done)
                begin
                    if (enc_reg)
                        a2_reg <= mm_res;
                    else
                        a1_reg <= mm_res;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    res_first_reg  <= a1_reg;
                    res_second_reg <= enc_reg ? a2_reg : '0;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({res_second_reg, res_first_reg});

    `EED_ASSERT_NOW(a_idle_unit_quiet, s_tready, !mm_stat.busy,
        "multiplier busy while core idle")
    `EED_ASSERT_NOW(a_done_when_issued, mm_stat.done, issued_reg,
        "multiplier result with no product issued")
    `EED_ASSERT_NEXT(a_leave_idle, in_acc, !s_tready,
        "core still ready after taking a transaction")

endmodule

### test/tb.sv
typedef enum logic {OP_ENCRYPT = 1'b0, OP_DECRYPT = 1'b1} cipher_op_t;

typedef struct {
    cipher_op_t  op;
    logic [31:0] msg;
    logic [31:0] rexp;
    logic [31:0] c1;
    logic [31:0] c2;
} cipher_req_t;

class cipher_scoreboard;
    logic [31:0] modulus;
    logic [31:0] gen;
    logic [31:0] pub;
    logic [31:0] priv;
    // packed {second, first} per outstanding request
    logic [63:0] cipher_q[$];
    int          errors;

    function new();
        modulus = eed_pkg::PRIME_RST;
        gen     = eed_pkg::GENERATOR_RST;
        pub     = eed_pkg::PUBLIC_RST;
        priv    = eed_pkg::PRIVATE_RST;
        errors  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            eed_pkg::REG_PRIME:     modulus = val;
            eed_pkg::REG_GENERATOR: gen = val;
            eed_pkg::REG_PUBLIC:    pub = val;
            eed_pkg::REG_PRIVATE:   priv = val;
            default: ;
        endcase
    endfunction

    // right-to-left square and multiply, products kept in 64 bits
    function logic [63:0] pow_mod(logic [63:0] base, logic [63:0] expo, logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1;
        if (m <= 64'd1)
            return 64'd0;
        base = base % m;
        while (expo != 64'd0)
        begin
            if (expo[0])
                acc = (acc * base) % m;
            expo = expo >> 1;
            base = (base * base) % m;
        end
        return acc;
    endfunction

    function logic [63:0] predict(cipher_req_t req);
        logic [63:0] p;
        logic [63:0] first;
        logic [63:0] second;
        logic [31:0] e;
        p      = {32'd0, modulus};
        first  = 64'd0;
        second = 64'd0;
        if (p > 64'd1)
        begin
            if (req.op == OP_ENCRYPT)
            begin
                first  = pow_mod({32'd0, gen}, {32'd0, req.rexp}, p);
                second = (({32'd0, req.msg} % p) * pow_mod({32'd0, pub}, {32'd0, req.rexp}, p)) % p;
            end
            else
            begin
                // exponent wraps at 32 bits
                e     = modulus - 32'd1 - priv;
                first = (pow_mod({32'd0, req.c1}, {32'd0, e}, p) * ({32'd0, req.c2} % p)) % p;
            end
        end
        return {second[31:0], first[31:0]};
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    function void note_request(cipher_req_t req);
        cipher_q.push_back(predict(req));
    endfunction

    function void check_result(logic [63:0] data);
        logic [63:0] want;
        if (cipher_q.size() == 0)
        begin
            flag($sformatf("result %h with no transaction outstanding", data));
            return;
        end
        want = cipher_q.pop_front();
        if (want[31:0] != data[31:0])
            flag($sformatf("result_first: expected %h, got %h", want[31:0], data[31:0]));
        if (want[63:32] != data[63:32])
            flag($sformatf("result_second: expected %h, got %h", want[63:32], data[63:32]));
    endfunction

    function int pending();
        return cipher_q.size();
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 14;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    // message_block, random_exponent, cipher_first, cipher_second
    logic [127:0] s_tdata;
    // req_type
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // result_first, result_second
    logic [63:0]  m_tdata;

    cipher_scoreboard sb;
    cipher_req_t      seen_req;
    logic             calm;
    int               cycles = 0;

    elgamal_encrypt_decrypt_32bit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // observe transactions on all three ports
    always @(posedge clk)
    begin
        if (cfg_we)
            sb.set_reg(cfg_index, cfg_data);
        if (s_tvalid && s_tready)
        begin
            seen_req.op   = cipher_op_t'(s_tuser[0]);
            seen_req.msg  = s_tdata[31:0];
            seen_req.rexp = s_tdata[63:32];
            seen_req.c1   = s_tdata[95:64];
            seen_req.c2   = s_tdata[127:96];
            sb.note_request(seen_req);
        end
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // result side back-pressure
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    task automatic send(cipher_op_t op, logic [31:0] a, logic [31:0] b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        // fields of the other mode get noise
        if (op == OP_ENCRYPT)
            s_tdata <= {$urandom, $urandom, b, a};
        else
            s_tdata <= {b, a, $urandom, $urandom};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // encrypt, then decrypt the ciphertext the encryption should give
    task automatic send_round_trip(logic [31:0] m, logic [31:0] r);
        cipher_req_t req;
        logic [63:0] ct;
        req.op   = OP_ENCRYPT;
        req.msg  = m;
        req.rexp = r;
        req.c1   = 32'd0;
        req.c2   = 32'd0;
        ct = sb.predict(req);
        send(OP_ENCRYPT, m, r);
        send(OP_DECRYPT, ct[31:0], ct[63:32]);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_config(logic [31:0] p, logic [31:0] g, logic [31:0] y, logic [31:0] d);
        logic [31:0] vals [4];
        vals[0] = p;
        vals[1] = g;
        vals[2] = y;
        vals[3] = d;
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[1:0];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        // let the monitor pick up the last write
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_prime(int k);
        case (k)
            0:       return 32'd2;
            1:       return 32'd3;
            2:       return 32'd7;
            3:       return 32'd257;
            4:       return 32'd65537;
            5:       return 32'd1000003;
            6:       return 32'd2147483647;
            default: return 32'hFFFFFFFB;
        endcase
    endfunction

    task automatic random_config();
        logic [31:0] p;
        logic [31:0] g;
        logic [31:0] y;
        logic [31:0] d;
        case ($urandom_range(0, 9))
            0:       p = $urandom;
            1:       p = $urandom_range(0, 1);
            2:       p = $urandom_range(2, 50);
            default: p = pick_prime($urandom_range(0, 7));
        endcase
        g = $urandom;
        if (p > 32'd3 && $urandom_range(0, 5) != 0)
            d = $urandom_range(1, p - 32'd2);
        else
            d = $urandom;
        if ($urandom_range(0, 4) == 0)
            y = $urandom;
        else
            y = 32'(sb.pow_mod({32'd0, g}, {32'd0, d}, {32'd0, p}));
        write_config(p, g, y, d);
    endtask

    initial
    begin
        int pick;
        int n;
        sb        = new();
        calm      = 1'b0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        m_tready  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // settings straight out of reset
        send(OP_ENCRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send(OP_DECRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF);
        wait_idle();

        // largest 32-bit prime, consistent key pair
        write_config(32'hFFFFFFFB, 32'd2,
                     32'(sb.pow_mod(64'd2, 64'h12345679, 64'hFFFFFFFB)),
                     32'h12345679);
        send(OP_ENCRYPT, 32'd0, 32'd0);
        send(OP_ENCRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send(OP_ENCRYPT, 32'hFFFFFFFB, 32'd1);
        send(OP_DECRYPT, 32'd0, 32'd0);
        send(OP_DECRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send(OP_DECRYPT, 32'd1, 32'hFFFFFFFA);
        send_round_trip(32'hDEADBEEF, $urandom);
        wait_idle();

        // modulus of one, then zero: everything collapses to zero
        write_config(32'd1, $urandom, $urandom, $urandom);
        send(OP_ENCRYPT, $urandom, $urandom);
        send(OP_DECRYPT, $urandom, $urandom);
        wait_idle();
        write_config(32'd0, $urandom, $urandom, $urandom);
        send(OP_ENCRYPT, $urandom, $urandom);
        send(OP_DECRYPT, $urandom, $urandom);
        wait_idle();

        // smallest modulus with a private key past p-2
        write_config(32'd2, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send(OP_ENCRYPT, 32'hFFFFFFFF, 32'h80000001);
        send(OP_DECRYPT, 32'h7FFFFFFF, 32'hFFFFFFFF);
        wait_idle();

        // all-ones modulus, zero key
        write_config(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0, 32'd0);
        send(OP_ENCRYPT, 32'hFFFFFFFE, 32'h55555555);
        send(OP_DECRYPT, 32'hAAAAAAAA, 32'hFFFFFFFE);
        wait_idle();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            random_config();
            calm = (ph == 2);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 3);
                if (pick <= 1)
                begin
                    send_round_trip($urandom, $urandom);
                    n += 2;
                end
                else
                begin
                    send(pick == 2 ? OP_ENCRYPT : OP_DECRYPT, $urandom, $urandom);
                    n += 1;
                end
            end
            wait_idle();
        end
        calm = 1'b0;

        wait_idle();
        repeat (5000) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
